>>> rtl/core/tsp_pkg.sv
`timescale 1ns / 1ps

package tsp_pkg;

    // default fraction bits of the speed word
    localparam int FRAC_BITS_DEF = 8;

    // register reset values
    localparam logic [15:0] VMAX_RST = 16'd1000;
    localparam logic [23:0] ACC_RST  = 24'd500;

    // microseconds per second
    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

    // serial multiplier operand widths: 2*a times step number
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 31;

    // register indexes
    localparam logic REG_MAX_SPEED = 1'b0;
    localparam logic REG_ACCEL     = 1'b1;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STEP  = 2'd1,
        OP_STOP  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        PH_STOP  = 2'd0,
        PH_ACCEL = 2'd1,
        PH_CRUISE = 2'd2,
        PH_DECEL = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        DIR_FWD   = 2'd0,
        DIR_BACK  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } t_dir;

endpackage

>>> rtl/core/tsp_mul.sv
`timescale 1ns / 1ps

// shift-add multiplier, one multiplier bit per cycle
module tsp_mul #(
    parameter int MA = tsp_pkg::MUL_A_W,
    parameter int MB = tsp_pkg::MUL_B_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MA-1:0]    i_a,
    input  logic [MB-1:0]    i_b,
    output logic             o_done,
    output logic [MA+MB-1:0] o_prod
);
    localparam int CW = $clog2(MB + 1);

    logic [MA:0]    r_hi;
    logic [MB-1:0]  r_lo;
    logic [MA-1:0]  r_a;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;

    logic [MA:0]       n_sum;
    logic [MA+MB:0]    n_cat;

    // add the multiplicand under the current bit, then shift right
    always_comb begin
        n_sum = r_hi + (r_lo[0] ? {1'b0, r_a} : '0);
        n_cat = {n_sum, r_lo} >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(MB);
                r_hi   <= '0;
                r_lo   <= i_b;
                r_a    <= i_a;
            end else if (r_busy) begin
                r_hi  <= n_cat[MA+MB:MB];
                r_lo  <= n_cat[MB-1:0];
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi[MA-1:0], r_lo};

endmodule

>>> rtl/core/tsp_sqrt.sv
`timescale 1ns / 1ps

// restoring square root, two radicand bits per cycle
module tsp_sqrt #(
    parameter int RW = 16 + tsp_pkg::FRAC_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [2*RW-1:0] i_rad,
    output logic            o_done,
    output logic [RW-1:0]   o_root
);
    localparam int CW = $clog2(RW + 1);

    logic [2*RW-1:0] r_rad;
    logic [RW:0]     r_rem;
    logic [RW-1:0]   r_root;
    logic [CW-1:0]   r_cnt;
    logic            r_busy;
    logic            r_done;

    logic [RW+2:0] n_sh;
    logic [RW+2:0] n_trial;
    logic [RW+2:0] n_diff;
    logic          n_ge;

    // bring down two bits, try root*4+1
    always_comb begin
        n_sh    = {r_rem, r_rad[2*RW-1 -: 2]};
        n_trial = {1'b0, r_root, 2'b01};
        n_ge    = (n_sh >= n_trial);
        n_diff  = n_sh - n_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(RW);
                r_rad  <= i_rad;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rad  <= r_rad << 2;
                r_rem  <= n_ge ? n_diff[RW:0] : n_sh[RW:0];
                r_root <= {r_root[RW-2:0], n_ge};
                r_cnt  <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

>>> rtl/core/tsp_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module tsp_div #(
    parameter int NW = 33,
    parameter int DW = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    localparam int CW = $clog2(NW + 1);

    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [NW-1:0] r_quo;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW:0] n_sh;
    logic [DW:0] n_diff;
    logic        n_ge;

    // shift in the next dividend bit and try the subtract
    always_comb begin
        n_sh   = {r_rem, r_quo[NW-1]};
        n_ge   = (n_sh >= {1'b0, r_den});
        n_diff = n_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_rem  <= '0;
                r_den  <= i_den;
                r_quo  <= i_num;
            end else if (r_busy) begin
                r_rem <= n_ge ? n_diff[DW-1:0] : n_sh[DW-1:0];
                r_quo <= {r_quo[NW-2:0], n_ge};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> rtl/core/trapezoid_stepper_profile.sv
`timescale 1ns / 1ps
// Stop, idle and ignored words pass from idle through S_OUT to the output register.
// Start: serial ramp-length divide in S_RAMP, then S_OUT.
// Ramp step: multiply, root (skipped when capped at max speed), divide, then S_OUT;
// cruise step: divide, then S_OUT. One word in flight; next accepted on return to idle.
// Reset (synchronous, active low): registers to 1000 / 500, motors off, no move.
module trapezoid_stepper_profile #(
    parameter int FRAC_BITS = tsp_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [30:0] i_step_total,
    input  logic [1:0]  i_direction,
    // result words
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_step_pulse,
    output logic [19:0] o_interval_us,
    output logic [1:0]  o_phase,
    output logic [23:0] o_speed_q8,
    output logic [30:0] o_steps_left,
    output logic        o_left_forward,
    output logic        o_right_forward,
    output logic        o_motors_enabled,
    output logic        o_move_done
);
    localparam int SW = 16 + FRAC_BITS;
    localparam int NW = (20 + FRAC_BITS > 33) ? 20 + FRAC_BITS : 33;
    localparam int DW = (SW > 25) ? SW : 25;
    localparam int MA = tsp_pkg::MUL_A_W;
    localparam int MB = tsp_pkg::MUL_B_W;
    localparam logic [NW-1:0] USEC_NUM = NW'(tsp_pkg::USEC_PER_SEC) << FRAC_BITS;
    localparam logic [SW-1:0] SPEED_ONE = SW'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RAMP,
        S_MUL,
        S_SQRT,
        S_DIV,
        S_OUT
    } t_state;

    t_state r_state;

    // configuration and move state
    logic [15:0] r_vmax;
    logic [23:0] r_acc;
    logic [31:0] r_vsq;
    logic        r_moving;
    logic [30:0] r_total;
    logic [30:0] r_idx;
    logic [30:0] r_up;
    logic [30:0] r_down;
    logic        r_left_dir;
    logic        r_right_dir;
    logic        r_enabled;

    // word in flight
    logic [30:0]         r_k;
    logic                r_p_pulse;
    tsp_pkg::t_phase     r_p_phase;
    logic [SW-1:0]       r_p_speed;
    logic [19:0]         r_p_interval;
    logic [30:0]         r_p_left;
    logic                r_p_done;

    // unit launch
    logic          r_mul_go;
    logic          r_sqrt_go;
    logic          r_div_go;
    logic [2*SW-1:0] r_rad;
    logic [NW-1:0] r_div_num;
    logic [DW-1:0] r_div_den;

    // output register
    logic        r_o_valid;
    logic        r_o_pulse;
    logic [19:0] r_o_interval;
    logic [1:0]  r_o_phase;
    logic [23:0] r_o_speed;
    logic [30:0] r_o_left;
    logic        r_o_lfwd;
    logic        r_o_rfwd;
    logic        r_o_en;
    logic        r_o_done;

    logic             mul_done;
    logic [MA+MB-1:0] mul_prod;
    logic             sqrt_done;
    logic [SW-1:0]    sqrt_root;
    logic             div_done;
    logic [NW-1:0]    div_quo;

    tsp_mul #(.MA(MA), .MB(MB)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_go),
        .i_a     ({r_acc, 1'b0}),
        .i_b     (r_k),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    tsp_sqrt #(.RW(SW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sqrt_go),
        .i_rad   (r_rad),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    tsp_div #(.NW(NW), .DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // configuration port
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == tsp_pkg::REG_ACCEL) ? {8'd0, r_acc} : {16'd0, r_vmax};

    // step decode from current move state
    logic        in_acc;
    logic        step_in_ramp_up;
    logic        step_in_ramp_dn;
    logic [30:0] step_left;
    logic [SW-1:0] vmax_q;
    logic [32:0] ramp_len;
    logic        ramp_overlap;
    logic [30:0] half_n;

    always_comb begin
        in_acc          = i_in_valid && (r_state == S_IDLE);
        step_in_ramp_up = (r_idx < r_up);
        step_in_ramp_dn = (({1'b0, r_idx} + {1'b0, r_down}) >= {1'b0, r_total});
        step_left       = r_total - r_idx - 31'd1;
        vmax_q          = SW'(r_vmax) << FRAC_BITS;
        ramp_len        = div_quo[32:0];
        ramp_overlap    = ({ramp_len, 1'b0} > {3'd0, r_total});
        half_n          = r_total >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vmax      <= tsp_pkg::VMAX_RST;
            r_acc       <= tsp_pkg::ACC_RST;
            r_vsq       <= {16'd0, tsp_pkg::VMAX_RST} * {16'd0, tsp_pkg::VMAX_RST};
            r_moving    <= 1'b0;
            r_total     <= '0;
            r_idx       <= '0;
            r_up        <= '0;
            r_down      <= '0;
            r_left_dir  <= 1'b0;
            r_right_dir <= 1'b0;
            r_enabled   <= 1'b0;
            r_mul_go    <= 1'b0;
            r_sqrt_go   <= 1'b0;
            r_div_go    <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_mul_go  <= 1'b0;
            r_sqrt_go <= 1'b0;
            r_div_go  <= 1'b0;

            // register writes, zero ignored; square of the speed kept alongside
            if (cfg_wr) begin
                if (paddr[2] == tsp_pkg::REG_MAX_SPEED) begin
                    if (pwdata[15:0] != 16'd0) begin
                        r_vmax <= pwdata[15:0];
                        r_vsq  <= {16'd0, pwdata[15:0]} * {16'd0, pwdata[15:0]};
                    end
                end else begin
                    if (pwdata[23:0] != 24'd0) r_acc <= pwdata[23:0];
                end
            end

            if (r_o_valid && i_out_ready && (r_state != S_OUT)) r_o_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        // idle result unless overwritten below
                        r_p_pulse    <= 1'b0;
                        r_p_phase    <= tsp_pkg::PH_STOP;
                        r_p_speed    <= '0;
                        r_p_interval <= '0;
                        r_p_left     <= '0;
                        r_p_done     <= 1'b0;
                        r_state      <= S_OUT;
                        if (i_op == tsp_pkg::OP_START && i_step_total != 31'd0) begin
                            r_left_dir  <= (i_direction == tsp_pkg::DIR_FWD) ||
                                           (i_direction == tsp_pkg::DIR_RIGHT);
                            r_right_dir <= (i_direction == tsp_pkg::DIR_FWD) ||
                                           (i_direction == tsp_pkg::DIR_LEFT);
                            r_enabled   <= 1'b1;
                            r_moving    <= 1'b1;
                            r_total     <= i_step_total;
                            r_idx       <= '0;
                            r_p_left    <= i_step_total;
                            // ramp length = (v^2 + a) / 2a
                            r_div_num   <= NW'({1'b0, r_vsq} + {9'd0, r_acc});
                            r_div_den   <= DW'({r_acc, 1'b0});
                            r_div_go    <= 1'b1;
                            r_state     <= S_RAMP;
                        end else if (i_op == tsp_pkg::OP_STEP && r_moving) begin
                            r_p_pulse <= 1'b1;
                            r_p_left  <= step_left;
                            r_idx     <= r_idx + 31'd1;
                            if (step_left == 31'd0) begin
                                r_moving  <= 1'b0;
                                r_enabled <= 1'b0;
                                r_p_done  <= 1'b1;
                            end
                            if (step_in_ramp_up) begin
                                r_p_phase <= tsp_pkg::PH_ACCEL;
                                r_k       <= r_idx + 31'd1;
                                r_mul_go  <= 1'b1;
                                r_state   <= S_MUL;
                            end else if (step_in_ramp_dn) begin
                                r_p_phase <= tsp_pkg::PH_DECEL;
                                r_k       <= r_total - r_idx;
                                r_mul_go  <= 1'b1;
                                r_state   <= S_MUL;
                            end else begin
                                r_p_phase <= tsp_pkg::PH_CRUISE;
                                r_p_speed <= vmax_q;
                                r_div_num <= USEC_NUM;
                                r_div_den <= DW'(vmax_q);
                                r_div_go  <= 1'b1;
                                r_state   <= S_DIV;
                            end
                        end else if (i_op == tsp_pkg::OP_STOP) begin
                            r_moving  <= 1'b0;
                            r_enabled <= 1'b0;
                            r_p_done  <= 1'b1;
                        end
                    end
                end
                S_RAMP: begin
                    if (div_done) begin
                        if (ramp_overlap) begin
                            r_up   <= half_n;
                            r_down <= r_total - half_n;
                        end else begin
                            r_up   <= ramp_len[30:0];
                            r_down <= ramp_len[30:0];
                        end
                        r_state <= S_OUT;
                    end
                end
                S_MUL: begin
                    if (mul_done) begin
                        if (mul_prod > {24'd0, r_vsq}) begin
                            r_p_speed <= vmax_q;
                            r_div_num <= USEC_NUM;
                            r_div_den <= DW'(vmax_q);
                            r_div_go  <= 1'b1;
                            r_state   <= S_DIV;
                        end else begin
                            r_rad     <= {mul_prod[31:0], {(2*FRAC_BITS){1'b0}}};
                            r_sqrt_go <= 1'b1;
                            r_state   <= S_SQRT;
                        end
                    end
                end
                S_SQRT: begin
                    if (sqrt_done) begin
                        r_p_speed <= (sqrt_root < SPEED_ONE) ? SPEED_ONE : sqrt_root;
                        r_div_num <= USEC_NUM;
                        r_div_den <= DW'((sqrt_root < SPEED_ONE) ? SPEED_ONE : sqrt_root);
                        r_div_go  <= 1'b1;
                        r_state   <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_p_interval <= div_quo[19:0];
                        r_state      <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_o_valid || i_out_ready) begin
                        r_o_valid    <= 1'b1;
                        r_o_pulse    <= r_p_pulse;
                        r_o_interval <= r_p_interval;
                        r_o_phase    <= r_p_phase;
                        r_o_speed    <= 24'(r_p_speed);
                        r_o_left     <= r_p_left;
                        r_o_lfwd     <= r_left_dir;
                        r_o_rfwd     <= r_right_dir;
                        r_o_en       <= r_enabled;
                        r_o_done     <= r_p_done;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_o_valid;
    assign o_step_pulse     = r_o_pulse;
    assign o_interval_us    = r_o_interval;
    assign o_phase          = r_o_phase;
    assign o_speed_q8       = r_o_speed;
    assign o_steps_left     = r_o_left;
    assign o_left_forward   = r_o_lfwd;
    assign o_right_forward  = r_o_rfwd;
    assign o_motors_enabled = r_o_en;
    assign o_move_done      = r_o_done;

    // a running move always has its drivers enabled
    a_move_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_moving |-> r_enabled)
        else $error("move running with motors disabled");

    // step index stays below the move length while moving
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_moving |-> (r_idx < r_total))
        else $error("step index past end of move");

    // a finished move reports motors off
    a_done_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_move_done) |-> !o_motors_enabled)
        else $error("done word with motors enabled");

    // every step word carries a nonzero wait
    a_pulse_interval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_step_pulse) |-> (o_interval_us != 20'd0))
        else $error("step word with zero interval");

endmodule

>>> tb/sv/tb_trapezoid_stepper_profile.sv
`timescale 1ns / 1ps

module tb_trapezoid_stepper_profile;

    localparam int FRAC     = tsp_pkg::FRAC_BITS_DEF;
    localparam int HOLDOFF  = 200;     // cycles after the last result before a register write
    localparam int WD_LIMIT = 20000;   // cycles without any accepted word or register access

    typedef struct packed {
        logic        step_pulse;
        logic [19:0] interval_us;
        logic [1:0]  phase;
        logic [23:0] speed_q8;
        logic [30:0] steps_left;
        logic        left_forward;
        logic        right_forward;
        logic        motors_enabled;
        logic        move_done;
    } t_step_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_op;
    logic [30:0] i_step_total;
    logic [1:0]  i_direction;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_step_pulse;
    logic [19:0] o_interval_us;
    logic [1:0]  o_phase;
    logic [23:0] o_speed_q8;
    logic [30:0] o_steps_left;
    logic        o_left_forward;
    logic        o_right_forward;
    logic        o_motors_enabled;
    logic        o_move_done;

    trapezoid_stepper_profile DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_op(i_op), .i_step_total(i_step_total), .i_direction(i_direction),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_step_pulse(o_step_pulse), .o_interval_us(o_interval_us),
        .o_phase(o_phase), .o_speed_q8(o_speed_q8), .o_steps_left(o_steps_left),
        .o_left_forward(o_left_forward), .o_right_forward(o_right_forward),
        .o_motors_enabled(o_motors_enabled), .o_move_done(o_move_done)
    );

    // clock
    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    // profile model state
    logic [15:0] cfg_vmax;
    logic [23:0] cfg_accel;
    logic        mv_moving;
    logic [30:0] mv_total;
    logic [30:0] mv_index;
    logic [30:0] mv_ramp_up;
    logic [30:0] mv_ramp_down;
    logic        mv_left_fwd;
    logic        mv_right_fwd;
    logic        mv_enabled;

    t_step_word expected_words[$];
    int send_idle_pct, recv_idle_pct;
    int err_count, items_sent, words_checked, pulses_seen, moves_started, cfg_writes;
    int idle_cycles;

    // integer square root, rounded down
    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] r, b;
        r = 64'd0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // ramp speed at step number k, Q.FRAC
    function automatic logic [63:0] ramp_speed_q(logic [30:0] k);
        logic [63:0] vm, lhs, s;
        vm  = {48'd0, cfg_vmax};
        lhs = 64'd2 * {40'd0, cfg_accel} * {33'd0, k};
        if (lhs > vm * vm) return vm << FRAC;
        s = isqrt64(lhs << (2 * FRAC));
        if (s < (64'd1 << FRAC)) s = 64'd1 << FRAC;
        return s;
    endfunction

    function automatic t_step_word make_word(logic pulse, logic [63:0] intv,
                                             tsp_pkg::t_phase ph,
                                             logic [63:0] spd, logic [30:0] left,
                                             logic done);
        t_step_word w;
        w.step_pulse     = pulse;
        w.interval_us    = intv[19:0];
        w.phase          = ph;
        w.speed_q8       = spd[23:0];
        w.steps_left     = left;
        w.left_forward   = mv_left_fwd;
        w.right_forward  = mv_right_fwd;
        w.motors_enabled = mv_enabled;
        w.move_done      = done;
        return w;
    endfunction

    // advance the profile model by one input word
    function automatic t_step_word profile_next(tsp_pkg::t_op op, logic [30:0] n,
                                                tsp_pkg::t_dir dir);
        logic [63:0] v, a, ramp, up, down, spd, intv;
        logic [30:0] left;
        tsp_pkg::t_phase ph;
        if (op == tsp_pkg::OP_START && n != 0) begin
            v    = {48'd0, cfg_vmax};
            a    = {40'd0, cfg_accel};
            ramp = (v * v + a) / (64'd2 * a);
            up   = ramp;
            down = ramp;
            if (up + down > {33'd0, n}) begin
                up   = {33'd0, n} / 2;
                down = {33'd0, n} - up;
            end
            mv_left_fwd  = (dir == tsp_pkg::DIR_FWD || dir == tsp_pkg::DIR_RIGHT);
            mv_right_fwd = (dir == tsp_pkg::DIR_FWD || dir == tsp_pkg::DIR_LEFT);
            mv_enabled   = 1'b1;
            mv_moving    = 1'b1;
            mv_total     = n;
            mv_index     = 31'd0;
            mv_ramp_up   = up[30:0];
            mv_ramp_down = down[30:0];
            moves_started++;
            return make_word(1'b0, 64'd0, tsp_pkg::PH_STOP, 64'd0, n, 1'b0);
        end
        if (op == tsp_pkg::OP_STEP && mv_moving) begin
            if (mv_index < mv_ramp_up) begin
                ph  = tsp_pkg::PH_ACCEL;
                spd = ramp_speed_q(mv_index + 31'd1);
            end else if ({33'd0, mv_index} + {33'd0, mv_ramp_down} >= {33'd0, mv_total}) begin
                ph  = tsp_pkg::PH_DECEL;
                spd = ramp_speed_q(mv_total - mv_index);
            end else begin
                ph  = tsp_pkg::PH_CRUISE;
                spd = {48'd0, cfg_vmax} << FRAC;
            end
            intv     = ({44'd0, tsp_pkg::USEC_PER_SEC} << FRAC) / spd;
            left     = mv_total - mv_index - 31'd1;
            mv_index = mv_index + 31'd1;
            if (left == 0) begin
                mv_moving  = 1'b0;
                mv_enabled = 1'b0;
            end
            return make_word(1'b1, intv, ph, spd, left, left == 0);
        end
        if (op == tsp_pkg::OP_STOP) begin
            mv_moving  = 1'b0;
            mv_enabled = 1'b0;
            return make_word(1'b0, 64'd0, tsp_pkg::PH_STOP, 64'd0, 31'd0, 1'b1);
        end
        return make_word(1'b0, 64'd0, tsp_pkg::PH_STOP, 64'd0, 31'd0, 1'b0);
    endfunction

    // send one input word, with random idle cycles ahead of it
    task automatic send_word(tsp_pkg::t_op op, logic [30:0] n, tsp_pkg::t_dir dir);
        bit first;
        first = 1'b1;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            if (first) i_in_valid <= 1'b0;
            first = 1'b0;
            // junk payload while idle
            i_op         <= 2'($urandom);
            i_step_total <= 31'($urandom);
            i_direction  <= 2'($urandom);
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_step_total <= n;
        i_direction  <= dir;
        do @(posedge i_clk); while (!o_in_ready);
        expected_words.push_back(profile_next(op, n, dir));
        items_sent++;
    endtask

    task automatic drain_words();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (HOLDOFF) @(posedge i_clk);
    endtask

    // register write through the APB port, only with the block idle
    task automatic write_reg(logic idx, logic [31:0] value);
        drain_words();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == tsp_pkg::REG_MAX_SPEED && value[15:0] != 0) cfg_vmax = value[15:0];
        if (idx == tsp_pkg::REG_ACCEL && value[23:0] != 0) cfg_accel = value[23:0];
        cfg_writes++;
    endtask

    // run a move, every step or 1 to 30 steps for moves over 400, plus the optional noise
    task automatic run_move(logic [30:0] n, tsp_pkg::t_dir dir, bit allow_stop);
        int steps;
        send_word(tsp_pkg::OP_START, n, dir);
        steps = (n > 400) ? $urandom_range(1, 30) : n;
        for (int s = 0; s < steps; s++) begin
            if (allow_stop && $urandom_range(0, 99) < 2) begin
                send_word(tsp_pkg::OP_STOP, 31'($urandom),
                          tsp_pkg::t_dir'($urandom_range(0, 3)));
                return;
            end
            if ($urandom_range(0, 99) < 3)
                send_word(tsp_pkg::t_op'($urandom_range(0, 3)), 31'($urandom),
                          tsp_pkg::t_dir'($urandom_range(0, 3)));
            send_word(tsp_pkg::OP_STEP, 31'($urandom), tsp_pkg::t_dir'($urandom_range(0, 3)));
        end
        if (n > 400 || $urandom_range(0, 9) == 0)
            send_word($urandom_range(0, 1) ? tsp_pkg::OP_STOP : tsp_pkg::OP_STEP,
                      31'($urandom), tsp_pkg::t_dir'($urandom_range(0, 3)));
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_step_word got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_step_pulse, o_interval_us, o_phase, o_speed_q8, o_steps_left,
                   o_left_forward, o_right_forward, o_motors_enabled, o_move_done};
            words_checked++;
            if (got.step_pulse) pulses_seen++;
            if (expected_words.size() == 0) begin
                err_count++;
                if (err_count <= 10) $display("ERROR: unexpected word %h", got);
            end else begin
                want = expected_words.pop_front();
                if (got !== want) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("ERROR: word %0d pulse %b/%b intv %0d/%0d ph %0d/%0d spd %0d/%0d left %0d/%0d dir %b%b/%b%b en %b/%b done %b/%b",
                                 words_checked, want.step_pulse, got.step_pulse,
                                 want.interval_us, got.interval_us, want.phase, got.phase,
                                 want.speed_q8, got.speed_q8, want.steps_left,
                                 got.steps_left, want.left_forward, want.right_forward,
                                 got.left_forward, got.right_forward,
                                 want.motors_enabled, got.motors_enabled,
                                 want.move_done, got.move_done);
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge i_clk) i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // watchdog on cycles with nothing accepted
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (psel && penable) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WD_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // defaults after reset, a short move
    task automatic test_reset_values();
        run_move(31'd12, tsp_pkg::DIR_FWD, 1'b0);
    endtask

    // field extremes and every special case
    task automatic test_directed();
        send_word(tsp_pkg::OP_START, 31'd0, tsp_pkg::DIR_RIGHT);      // zero-length start
        send_word(tsp_pkg::OP_STEP, 31'h7FFF_FFFF, tsp_pkg::DIR_LEFT); // step while idle
        send_word(tsp_pkg::OP_NONE, 31'h7FFF_FFFF, tsp_pkg::DIR_RIGHT);
        send_word(tsp_pkg::OP_STOP, 31'd0, tsp_pkg::DIR_FWD);
        send_word(tsp_pkg::OP_START, 31'd1, tsp_pkg::DIR_BACK);
        send_word(tsp_pkg::OP_STEP, 31'd0, tsp_pkg::DIR_FWD);  // last step of a one-step move
        send_word(tsp_pkg::OP_STEP, 31'd0, tsp_pkg::DIR_FWD);
        send_word(tsp_pkg::OP_START, 31'h7FFF_FFFF, tsp_pkg::DIR_RIGHT);
        send_word(tsp_pkg::OP_STEP, 31'd0, tsp_pkg::DIR_FWD);
        send_word(tsp_pkg::OP_STEP, 31'd0, tsp_pkg::DIR_FWD);
        send_word(tsp_pkg::OP_START, 31'd5, tsp_pkg::DIR_LEFT);        // restart while moving
        send_word(tsp_pkg::OP_START, 31'd0, tsp_pkg::DIR_FWD);
        for (int s = 0; s < 5; s++) send_word(tsp_pkg::OP_STEP, 31'd0, tsp_pkg::DIR_BACK);
        send_word(tsp_pkg::OP_START, 31'd4, tsp_pkg::DIR_FWD);
        send_word(tsp_pkg::OP_STEP, 31'd0, tsp_pkg::DIR_FWD);
        send_word(tsp_pkg::OP_STOP, 31'h7FFF_FFFF, tsp_pkg::DIR_RIGHT);
        send_word(tsp_pkg::OP_STEP, 31'd0, tsp_pkg::DIR_FWD);
    endtask

    // register extremes, including ignored zero writes
    task automatic test_register_extremes();
        write_reg(tsp_pkg::REG_MAX_SPEED, 32'd1);
        write_reg(tsp_pkg::REG_ACCEL, 32'hFFFF_FFFF);
        run_move(31'd3, tsp_pkg::DIR_RIGHT, 1'b0);
        write_reg(tsp_pkg::REG_MAX_SPEED, 32'hFFFF_FFFF);
        write_reg(tsp_pkg::REG_ACCEL, 32'd1);
        run_move(31'd6, tsp_pkg::DIR_LEFT, 1'b0);
        write_reg(tsp_pkg::REG_MAX_SPEED, 32'h0000_0000);
        write_reg(tsp_pkg::REG_ACCEL, 32'hFF00_0000);
        run_move(31'd3, tsp_pkg::DIR_BACK, 1'b0);
        write_reg(tsp_pkg::REG_MAX_SPEED, 32'd40);
        write_reg(tsp_pkg::REG_ACCEL, 32'd100);
        run_move(31'd40, tsp_pkg::DIR_FWD, 1'b0);
    endtask

    // random moves with random register settings
    task automatic test_random_moves(int item_goal);
        int stop_at;
        logic [30:0] n;
        stop_at = items_sent + item_goal;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 3))
                    0: write_reg(tsp_pkg::REG_MAX_SPEED, 32'd1);
                    1: write_reg(tsp_pkg::REG_MAX_SPEED, 32'd65535);
                    2: write_reg(tsp_pkg::REG_MAX_SPEED, $urandom_range(1, 3000));
                    default: write_reg(tsp_pkg::REG_MAX_SPEED, $urandom);
                endcase
                case ($urandom_range(0, 3))
                    0: write_reg(tsp_pkg::REG_ACCEL, 32'd1);
                    1: write_reg(tsp_pkg::REG_ACCEL, 32'd16777215);
                    2: write_reg(tsp_pkg::REG_ACCEL, $urandom_range(1, 20000));
                    default: write_reg(tsp_pkg::REG_ACCEL, $urandom);
                endcase
            end
            case ($urandom_range(0, 19))
                0:       n = 31'($urandom);
                1, 2, 3: n = 31'($urandom_range(1, 400));
                default: n = 31'($urandom_range(1, 60));
            endcase
            run_move(n, tsp_pkg::t_dir'($urandom_range(0, 3)), 1'b1);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = 3'd0;
        pwdata       = 32'd0;
        i_in_valid   = 1'b0;
        i_op         = tsp_pkg::OP_NONE;
        i_step_total = 31'd0;
        i_direction  = tsp_pkg::DIR_FWD;
        i_out_ready  = 1'b0;
        idle_cycles  = 0;
        err_count = 0; items_sent = 0; words_checked = 0; pulses_seen = 0;
        moves_started = 0; cfg_writes = 0;
        send_idle_pct = 37;
        recv_idle_pct = 72;
        cfg_vmax = tsp_pkg::VMAX_RST;  cfg_accel = tsp_pkg::ACC_RST;
        mv_moving = 1'b0;     mv_total = '0;      mv_index = '0;
        mv_ramp_up = '0;      mv_ramp_down = '0;
        mv_left_fwd = 1'b0;   mv_right_fwd = 1'b0; mv_enabled = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_directed();
        test_register_extremes();
        test_random_moves(530);
        send_idle_pct = 72;
        recv_idle_pct = 37;
        test_random_moves(530);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_moves(530);
        drain_words();

        $display("Covered %0d input words, %0d results, %0d step pulses, %0d moves, %0d writes",
                 items_sent, words_checked, pulses_seen, moves_started, cfg_writes);
        $display("Mismatches: %0d", err_count);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
